FILE: src/carw_pkg.sv
// ----------------------------------------------------------------------------
// carw_pkg
// Shared types and constants for the cartridge adapter register window.
// ----------------------------------------------------------------------------
package carw_pkg;

	localparam int AddrW = 16;
	localparam int ByteW = 8;
	localparam int OpW   = 3;

	localparam logic [3:0] RegionPower  = 4'h8;
	localparam logic [3:0] RegionBank   = 4'hA;
	localparam logic [3:0] RegionStatus = 4'hB;

	localparam logic [ByteW-1:0] PowerOnCode  = 8'h84;
	localparam logic [ByteW-1:0] StatusBad    = 8'h40;
	localparam logic [ByteW-1:0] StatusPower  = 8'h80;
	localparam logic [ByteW-1:0] StatusEnable = 8'h01;
	localparam logic [ByteW-1:0] StatusReset  = 8'h04;
	localparam logic [ByteW-1:0] StatusSeen   = 8'h08;
	localparam logic [ByteW-1:0] OpenBusByte  = 8'hFF;

	typedef enum logic [OpW-1:0] {
		CART_NONE      = 3'd0,
		CART_ROM_READ  = 3'd1,
		CART_RAM_READ  = 3'd2,
		CART_MAP_WRITE = 3'd3,
		CART_RAM_WRITE = 3'd4
	} cart_op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_HOLD = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
	} carw_cmd_t;

	function automatic logic [ByteW-1:0] build_status(input logic powered,
		input logic enabled, input logic resetting, input logic seen);
		logic [ByteW-1:0] v;
		v = '0;
		if (powered) begin
			v = StatusPower;
			if (enabled)   v = v | StatusEnable;
			if (resetting) v = v | StatusReset;
			if (seen)      v = v | StatusSeen;
		end
		return v;
	endfunction

endpackage

FILE: src/carw_ctrl.sv
// ----------------------------------------------------------------------------
// carw_ctrl
// Handshake controller: takes a word, holds the result until it is taken.
// ----------------------------------------------------------------------------
module carw_ctrl import carw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output carw_cmd_t cmd
);

	ctrl_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) state_next = ST_HOLD;
			end
			ST_HOLD: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				cmd.load  = in_valid & out_ready;
				if (out_ready && !in_valid) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

endmodule

FILE: src/carw_datapath.sv
// ----------------------------------------------------------------------------
// carw_datapath
// Register file, address decode, bank translation and result register.
// ----------------------------------------------------------------------------
module carw_datapath import carw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  carw_cmd_t        cmd,
	input  logic             kind,
	input  logic [AddrW-1:0] address,
	input  logic [ByteW-1:0] write_data,
	output logic [ByteW-1:0] read_data,
	output cart_op_t         cart_op,
	output logic [AddrW-1:0] cart_address,
	output logic [ByteW-1:0] cart_data,
	output logic             invalid_access
);

	logic             powered_q, enable_q, resetting_q, seen_q;
	logic [ByteW-1:0] bank_q, status_q;

	logic             powered_n, enable_n, resetting_n, seen_n;
	logic [ByteW-1:0] bank_n, status_n;
	logic [ByteW-1:0] rd_n, cdata_n;
	cart_op_t         op_n;
	logic [AddrW-1:0] caddr_n, xlat;
	logic             bad_n;
	logic [3:0]       region;

	assign region = address[AddrW-1:AddrW-4];
	assign xlat   = {bank_q[1:0], address[AddrW-3:0]};

	always_comb begin
		powered_n   = powered_q;
		enable_n    = enable_q;
		resetting_n = resetting_q;
		seen_n      = seen_q;
		bank_n      = bank_q;
		status_n    = status_q;
		rd_n        = '0;
		op_n        = CART_NONE;
		caddr_n     = '0;
		cdata_n     = '0;
		bad_n       = 1'b0;
		if (!kind && !powered_q) begin
			rd_n = '0;
		end else if (region == RegionPower) begin
			if (kind) begin
				powered_n = (write_data == PowerOnCode);
				if (powered_n && !powered_q) begin
					resetting_n = 1'b1;
					seen_n      = 1'b1;
				end else if (!powered_n) begin
					enable_n    = 1'b0;
					resetting_n = 1'b0;
					seen_n      = 1'b0;
				end
				status_n = build_status(powered_n, enable_n, resetting_n, seen_n);
			end else begin
				rd_n = PowerOnCode;
			end
		end else if (region == RegionBank) begin
			if (kind) bank_n = write_data;
			else rd_n = bank_q;
		end else if (region == RegionStatus) begin
			if (kind) begin
				enable_n = write_data[0];
				if (enable_n && !enable_q) begin
					resetting_n = 1'b1;
					seen_n      = 1'b1;
				end
				status_n = build_status(powered_q, enable_n, resetting_n, seen_n);
			end else begin
				rd_n = status_q;
				if (resetting_q) begin
					resetting_n = 1'b0;
					status_n = build_status(powered_q, enable_q, 1'b0, seen_q);
				end
			end
		end else if (address[AddrW-1:AddrW-2] == 2'b11) begin
			if (powered_q && enable_q) begin
				if (!xlat[AddrW-1]) begin
					op_n    = kind ? CART_MAP_WRITE : CART_ROM_READ;
					caddr_n = xlat;
					if (kind) cdata_n = write_data;
				end else if (xlat[AddrW-1:AddrW-3] == 3'b101) begin
					op_n    = kind ? CART_RAM_WRITE : CART_RAM_READ;
					caddr_n = xlat;
					if (kind) cdata_n = write_data;
				end else if (!kind) begin
					rd_n = OpenBusByte;
				end
			end else if (!kind) begin
				rd_n = OpenBusByte;
			end
		end else begin
			status_n = StatusBad;
			bad_n    = 1'b1;
			if (!kind) rd_n = OpenBusByte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			powered_q   <= 1'b0;
			enable_q    <= 1'b0;
			resetting_q <= 1'b0;
			seen_q      <= 1'b0;
			bank_q      <= '0;
			status_q    <= '0;
		end else if (cmd.load) begin
			powered_q   <= powered_n;
			enable_q    <= enable_n;
			resetting_q <= resetting_n;
			seen_q      <= seen_n;
			bank_q      <= bank_n;
			status_q    <= status_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_data      <= rd_n;
			cart_op        <= op_n;
			cart_address   <= caddr_n;
			cart_data      <= cdata_n;
			invalid_access <= bad_n;
		end
	end

endmodule

FILE: src/cartridge_adapter_register_window.sv
// ----------------------------------------------------------------------------
// cartridge_adapter_register_window
// Bus register window of a cartridge adapter: power, bank and status
// registers plus a banked window forwarded as cartridge requests.
// ----------------------------------------------------------------------------
// Timing: a result word is valid in the cycle after its input word is taken.
// Throughput: one word per cycle while the output side keeps taking results;
// a new word enters in the cycle its predecessor's result is taken.
// Reset: arst_n clears all flags, bank and status to zero and drops any held
// result (m_tvalid low); the result register contents are not cleared.
module cartridge_adapter_register_window import carw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // address[15:0], write_data[23:16]
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // read_data[7:0], cart_address[23:8], cart_data[31:24]
	output logic [3:0]  m_tuser   // cart_op[2:0], invalid_access[3]
);

	carw_cmd_t        cmd;
	logic [ByteW-1:0] read_data, cart_data;
	cart_op_t         cart_op;
	logic [AddrW-1:0] cart_address;
	logic             invalid_access;

	carw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	carw_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.kind           (s_tuser),
		.address        (s_tdata[15:0]),
		.write_data     (s_tdata[23:16]),
		.read_data      (read_data),
		.cart_op        (cart_op),
		.cart_address   (cart_address),
		.cart_data      (cart_data),
		.invalid_access (invalid_access)
	);

	assign m_tdata = {cart_data, cart_address, read_data};
	assign m_tuser = {invalid_access, cart_op};

endmodule
